### rtl/iucf_pkg.sv
`default_nettype none

package iucf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IFC_W    = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned IHL_W    = 4;
    localparam int unsigned PROTO_W  = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned IN_DATA_W  = BYTE_W + IFC_W;
    localparam int unsigned OUT_DATA_W = IFC_W + LEN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_PORT    = 1'b0,
        CFG_CAPTURE_LIMIT = 1'b1
    } cfg_index_t;

    localparam logic [PORT_W-1:0]  MATCH_PORT_RESET    = 16'd52719;
    localparam logic [LEN_W-1:0]   CAPTURE_LIMIT_RESET = 16'd2048;

    localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;
    localparam logic [15:0]        FRAG_ANY_MASK  = 16'h3FFF;
    localparam logic [15:0]        FRAG_OFF_MASK  = 16'h1FFF;

    localparam logic [LEN_W-1:0] POS_ETYPE_HI = 16'd12;
    localparam logic [LEN_W-1:0] POS_ETYPE_LO = 16'd13;
    localparam logic [LEN_W-1:0] POS_IHL      = 16'd14;
    localparam logic [LEN_W-1:0] POS_FRAG_HI  = 16'd20;
    localparam logic [LEN_W-1:0] POS_FRAG_LO  = 16'd21;
    localparam logic [LEN_W-1:0] POS_PROTO    = 16'd23;
    localparam logic [LEN_W-1:0] MIN_IP_FRAME = 16'd34;
    localparam logic [LEN_W-1:0] LEN_MAX      = 16'hFFFF;

    localparam logic [6:0] PORT_HI_BASE = 7'd16;
    localparam logic [6:0] UDP_END_BASE = 7'd22;

endpackage

`default_nettype wire

### rtl/ipv4_udp_port_capture_filter_core.sv
`default_nettype none

// Byte-serial IPv4/UDP capture filter: takes one frame byte per transfer and, on the byte
// marked tlast, emits one verdict transfer (tuser 1 = capture, 0 = pass); a capture carries
// the ingress interface and the frame length capped at capture_limit, a pass carries zeros.
// One byte is taken every cycle; the header fields are gathered on the fly and the verdict
// is formed in the same cycle as the last byte and held in a single output register, so a
// stalled verdict holds the input only while that register is full and not being drained.
// Configuration writes are one-cycle and take effect at once; write them between frames.
module ipv4_udp_port_capture_filter_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_we,
    input  wire logic [iucf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]                     cfg_data,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [iucf_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // frame_byte, ingress_port_id
    input  wire logic                            s_axis_tlast,   // last_byte

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [iucf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // interface_id, reported_length
    output logic                                 m_axis_tuser    // verdict
);

    logic [iucf_pkg::PORT_W-1:0]  match_port_reg;
    logic [iucf_pkg::LEN_W-1:0]   capture_limit_reg;

    logic [iucf_pkg::LEN_W-1:0]   byte_count_reg, byte_count_next;
    logic [15:0]                  ether_kind_reg, ether_kind_next;
    logic [iucf_pkg::IHL_W-1:0]   header_words_reg, header_words_next;
    logic [15:0]                  fragment_field_reg, fragment_field_next;
    logic [iucf_pkg::PROTO_W-1:0] ip_protocol_reg, ip_protocol_next;
    logic [iucf_pkg::PORT_W-1:0]  dest_port_reg, dest_port_next;

    logic                         out_valid_reg;
    logic                         verdict_reg, verdict_next;
    logic [iucf_pkg::IFC_W-1:0]   ifc_reg, ifc_next;
    logic [iucf_pkg::LEN_W-1:0]   rep_len_reg, rep_len_next;

    logic                         in_xfer;
    logic                         out_xfer;
    logic [iucf_pkg::BYTE_W-1:0]  in_byte;
    logic [iucf_pkg::IFC_W-1:0]   in_ifc;
    logic [6:0]                   port_at;
    logic [6:0]                   udp_end;
    logic                         is_frag;
    logic                         capture;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    assign in_byte = s_axis_tdata[iucf_pkg::BYTE_W-1:0];
    assign in_ifc  = s_axis_tdata[iucf_pkg::IN_DATA_W-1:iucf_pkg::BYTE_W];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = verdict_reg;
    assign m_axis_tdata  = {rep_len_reg, ifc_reg};

    // header capture at fixed offsets, port at 16 + ihl*4
    assign port_at = iucf_pkg::PORT_HI_BASE + {1'b0, header_words_reg, 2'b00};

    always_comb
    begin
        ether_kind_next     = ether_kind_reg;
        header_words_next   = header_words_reg;
        fragment_field_next = fragment_field_reg;
        ip_protocol_next    = ip_protocol_reg;
        dest_port_next      = dest_port_reg;

        if (byte_count_reg == iucf_pkg::POS_ETYPE_HI)
            ether_kind_next[15:8] = in_byte;
        if (byte_count_reg == iucf_pkg::POS_ETYPE_LO)
            ether_kind_next[7:0] = in_byte;
        if (byte_count_reg == iucf_pkg::POS_IHL)
            header_words_next = in_byte[iucf_pkg::IHL_W-1:0];
        if (byte_count_reg == iucf_pkg::POS_FRAG_HI)
            fragment_field_next[15:8] = in_byte;
        if (byte_count_reg == iucf_pkg::POS_FRAG_LO)
            fragment_field_next[7:0] = in_byte;
        if (byte_count_reg == iucf_pkg::POS_PROTO)
            ip_protocol_next = in_byte;
        if (byte_count_reg > iucf_pkg::POS_IHL)
        begin
            if (byte_count_reg == {9'd0, port_at})
                dest_port_next[15:8] = in_byte;
            if (byte_count_reg == {9'd0, port_at + 7'd1})
                dest_port_next[7:0] = in_byte;
        end

        byte_count_next = (byte_count_reg == iucf_pkg::LEN_MAX) ? byte_count_reg
                                                                : byte_count_reg + 16'd1;
    end

    // verdict from the header as it stands after this byte
    assign udp_end = iucf_pkg::UDP_END_BASE + {1'b0, header_words_next, 2'b00};
    assign is_frag = (fragment_field_next & iucf_pkg::FRAG_ANY_MASK) != 16'd0;

    always_comb
    begin
        capture = 1'b0;
        if (byte_count_next >= iucf_pkg::MIN_IP_FRAME
            && ether_kind_next == iucf_pkg::ETHERTYPE_IPV4)
        begin
            if (is_frag)
                capture = 1'b1;
            else
                capture = (ip_protocol_next == iucf_pkg::PROTO_UDP)
                          && ({9'd0, udp_end} <= byte_count_next)
                          && (dest_port_next == match_port_reg);
        end

        verdict_next = capture;
        ifc_next     = capture ? in_ifc : '0;
        if (!capture)
            rep_len_next = '0;
        else if (byte_count_next > capture_limit_reg)
            rep_len_next = capture_limit_reg;
        else
            rep_len_next = byte_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg     <= iucf_pkg::MATCH_PORT_RESET;
            capture_limit_reg  <= iucf_pkg::CAPTURE_LIMIT_RESET;
            byte_count_reg     <= '0;
            ether_kind_reg     <= '0;
            header_words_reg   <= '0;
            fragment_field_reg <= '0;
            ip_protocol_reg    <= '0;
            dest_port_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (iucf_pkg::cfg_index_t'(cfg_index))
                    iucf_pkg::CFG_MATCH_PORT:    match_port_reg    <= cfg_data;
                    iucf_pkg::CFG_CAPTURE_LIMIT: capture_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_xfer)
            begin
                if (s_axis_tlast)
                begin
                    byte_count_reg     <= '0;
                    ether_kind_reg     <= '0;
                    header_words_reg   <= '0;
                    fragment_field_reg <= '0;
                    ip_protocol_reg    <= '0;
                    dest_port_reg      <= '0;
                end
                else
                begin
                    byte_count_reg     <= byte_count_next;
                    ether_kind_reg     <= ether_kind_next;
                    header_words_reg   <= header_words_next;
                    fragment_field_reg <= fragment_field_next;
                    ip_protocol_reg    <= ip_protocol_next;
                    dest_port_reg      <= dest_port_next;
                end
            end

            if (in_xfer && s_axis_tlast)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_axis_tlast)
        begin
            verdict_reg <= verdict_next;
            ifc_reg     <= ifc_next;
            rep_len_reg <= rep_len_next;
        end
    end

`ifndef SYNTH
    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tlast |=> byte_count_reg == '0)
        else $error("byte count not cleared after last byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_axis_tlast |=> m_axis_tvalid)
        else $error("no verdict after last byte");

    a_pass_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("pass verdict carries nonzero data");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while verdict register is blocked");
`endif

endmodule

`default_nettype wire

### sim/capture_verdict_checker.sv
`default_nettype none

module capture_verdict_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire logic [iucf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                      cfg_data,

    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [iucf_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // frame_byte, ingress_port_id
    input  wire logic                             s_axis_tlast,   // last_byte

    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [iucf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // interface_id, reported_length
    input  wire logic                             m_axis_tuser,   // verdict

    output int                                    fail_count,
    output int                                    pending_verdicts,
    output int                                    captures_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        verdict;
        logic [iucf_pkg::IFC_W-1:0]  interface_id;
        logic [iucf_pkg::LEN_W-1:0]  reported_length;
    } verdict_t;

    verdict_t                      expected_verdicts[$];

    logic [iucf_pkg::PORT_W-1:0]   match_port;
    logic [iucf_pkg::LEN_W-1:0]    capture_limit;

    logic [iucf_pkg::LEN_W-1:0]    byte_count;
    logic [15:0]                   ether_kind;
    logic [iucf_pkg::IHL_W-1:0]    header_words;
    logic [15:0]                   fragment_field;
    logic [iucf_pkg::PROTO_W-1:0]  ip_protocol;
    logic [iucf_pkg::PORT_W-1:0]   dest_port_seen;

    initial
    begin
        fail_count       = 0;
        pending_verdicts = 0;
        captures_seen    = 0;
    end

    function automatic logic capture_wanted(input int unsigned len);
        logic        frag_flag;
        int unsigned udp_end;
        frag_flag = (fragment_field & iucf_pkg::FRAG_ANY_MASK) != 16'h0;
        udp_end   = 22 + int'(header_words) * 4;
        if (len < 14 || ether_kind != iucf_pkg::ETHERTYPE_IPV4 || len < 34)
            return 1'b0;
        if (ip_protocol != iucf_pkg::PROTO_UDP && !frag_flag)
            return 1'b0;
        if (!frag_flag || (fragment_field & iucf_pkg::FRAG_OFF_MASK) == 16'h0)
        begin
            if (udp_end > len)
            begin
                if (!frag_flag)
                    return 1'b0;
            end
            else if (dest_port_seen != match_port && !frag_flag)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_frame();
        byte_count     = '0;
        ether_kind     = '0;
        header_words   = '0;
        fragment_field = '0;
        ip_protocol    = '0;
        dest_port_seen = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               input logic [iucf_pkg::IFC_W-1:0] ifc);
        int unsigned pos;
        int unsigned port_at;
        verdict_t    outcome;
        pos     = byte_count;
        port_at = 16 + int'(header_words) * 4;
        if (pos == 12) ether_kind[15:8] = b;
        if (pos == 13) ether_kind[7:0]  = b;
        if (pos == 14)
        begin
            header_words = b[3:0];
            port_at      = 16 + int'(header_words) * 4;
        end
        if (pos == 20) fragment_field[15:8] = b;
        if (pos == 21) fragment_field[7:0]  = b;
        if (pos == 23) ip_protocol = b;
        if (pos > 14)
        begin
            if (pos == port_at)     dest_port_seen[15:8] = b;
            if (pos == port_at + 1) dest_port_seen[7:0]  = b;
        end
        if (byte_count != iucf_pkg::LEN_MAX)
            byte_count = byte_count + 16'd1;
        if (last)
        begin
            outcome = '0;
            if (capture_wanted(byte_count))
            begin
                outcome.verdict         = 1'b1;
                outcome.interface_id    = ifc;
                outcome.reported_length = (byte_count > capture_limit) ? capture_limit
                                                                       : byte_count;
            end
            expected_verdicts.push_back(outcome);
            clear_frame();
        end
    endtask

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        $error("%s: expected %0d, got %0d", field, want, got);
        fail_count++;
    endtask

    task automatic compare_verdict();
        verdict_t want;
        if (expected_verdicts.size() == 0)
        begin
            $error("verdict transfer with nothing outstanding: tuser %0d tdata %h",
                   m_axis_tuser, m_axis_tdata);
            fail_count++;
            return;
        end
        want = expected_verdicts.pop_front();
        if (m_axis_tuser !== want.verdict)
            report_mismatch("verdict", want.verdict, m_axis_tuser);
        if (m_axis_tdata[iucf_pkg::IFC_W-1:0] !== want.interface_id)
            report_mismatch("interface_id", want.interface_id,
                            m_axis_tdata[iucf_pkg::IFC_W-1:0]);
        if (m_axis_tdata[iucf_pkg::IFC_W +: iucf_pkg::LEN_W] !== want.reported_length)
            report_mismatch("reported_length", want.reported_length,
                            m_axis_tdata[iucf_pkg::IFC_W +: iucf_pkg::LEN_W]);
        if (m_axis_tuser === 1'b1)
            captures_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port    = iucf_pkg::MATCH_PORT_RESET;
            capture_limit = iucf_pkg::CAPTURE_LIMIT_RESET;
            clear_frame();
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == iucf_pkg::CFG_MATCH_PORT)
                    match_port = cfg_data;
                else if (cfg_index == iucf_pkg::CFG_CAPTURE_LIMIT)
                    capture_limit = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata[iucf_pkg::BYTE_W-1:0], s_axis_tlast,
                            s_axis_tdata[iucf_pkg::IN_DATA_W-1:iucf_pkg::BYTE_W]);
            if (m_axis_tvalid && m_axis_tready)
                compare_verdict();
        end
        pending_verdicts = expected_verdicts.size();
    end

endmodule

`default_nettype wire

### sim/ipv4_udp_port_capture_filter_core_test.sv
`default_nettype none

module ipv4_udp_port_capture_filter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int PHASE_BYTES  = 120;
    localparam int PHASE_COUNT  = 8;

    logic                             clk;
    logic                             rst_n;

    logic                             cfg_we;
    logic [iucf_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [15:0]                      cfg_data;

    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [iucf_pkg::IN_DATA_W-1:0]   s_axis_tdata;   // frame_byte, ingress_port_id
    logic                             s_axis_tlast;   // last_byte

    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [iucf_pkg::OUT_DATA_W-1:0]  m_axis_tdata;   // interface_id, reported_length
    logic                             m_axis_tuser;   // verdict

    int                               fail_count;
    int                               pending_verdicts;
    int                               captures_seen;

    int                               send_idle_pct;
    int                               recv_stall_pct;
    int                               cycle_count;
    int                               frames_sent;
    int                               bytes_sent;
    logic [iucf_pkg::PORT_W-1:0]      port_now;
    logic [7:0]                       frame_buf[$];

    ipv4_udp_port_capture_filter_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    capture_verdict_checker u_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .fail_count       (fail_count),
        .pending_verdicts (pending_verdicts),
        .captures_seen    (captures_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** ipv4_udp_port_capture_filter_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_frame(input int len, input logic [15:0] etype,
                              input logic [7:0] ver_ihl, input logic [15:0] frag,
                              input logic [7:0] proto, input logic [15:0] dport);
        int port_at;
        port_at = 16 + int'(ver_ihl[3:0]) * 4;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(8'($urandom));
        if (len > port_at)     frame_buf[port_at]     = dport[15:8];
        if (len > port_at + 1) frame_buf[port_at + 1] = dport[7:0];
        if (len > 12) frame_buf[12] = etype[15:8];
        if (len > 13) frame_buf[13] = etype[7:0];
        if (len > 14) frame_buf[14] = ver_ihl;
        if (len > 20) frame_buf[20] = frag[15:8];
        if (len > 21) frame_buf[21] = frag[7:0];
        if (len > 23) frame_buf[23] = proto;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {32'($urandom), frame_buf[i]};
            s_axis_tlast  <= (i == frame_buf.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    task automatic random_frame();
        int                kind;
        int                ihl;
        int                len;
        logic [15:0]       etype;
        logic [15:0]       frag;
        logic [7:0]        proto;
        logic [15:0]       dport;
        kind  = $urandom_range(99);
        ihl   = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
        etype = iucf_pkg::ETHERTYPE_IPV4;
        proto = iucf_pkg::PROTO_UDP;
        frag  = $urandom_range(1) ? 16'h0000 : 16'h4000;
        dport = ($urandom_range(9) < 6) ? port_now : 16'($urandom);
        len   = 30 + ihl * 4 + $urandom_range(24);
        if ($urandom_range(7) == 0)
            len = $urandom_range(14, 30 + ihl * 4);
        if (kind < 20)
        begin
            // fragments: first ones and later ones
            frag  = {3'($urandom), $urandom_range(1) ? 13'h0 : 13'($urandom)};
            proto = 8'($urandom);
        end
        else if (kind < 35)
            proto = 8'($urandom);
        else if (kind < 50)
        begin
            etype = $urandom_range(1) ? 16'($urandom) : iucf_pkg::ETHERTYPE_IPV4;
            frag  = 16'($urandom);
            len   = $urandom_range(1, 60);
        end
        if ($urandom_range(24) == 0)
            len += $urandom_range(300);
        send_frame(len, etype, {4'($urandom), 4'(ihl)}, frag, proto, dport);
    endtask

    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_registers(input logic [15:0] port, input logic [15:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= iucf_pkg::CFG_MATCH_PORT;
        cfg_data  <= port;
        @(posedge clk);
        cfg_index <= iucf_pkg::CFG_CAPTURE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        port_now = port;
    endtask

    initial
    begin
        int phase_start;
        cycle_count    <= 0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= iucf_pkg::CFG_MATCH_PORT;
        cfg_data       <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tlast   <= 1'b0;
        m_axis_tready  <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frames_sent    = 0;
        bytes_sent     = 0;
        port_now       = iucf_pkg::MATCH_PORT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed frames with reset register values
        send_frame(1, 16'h0000, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP, port_now);
        send_frame(13, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(14, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(60, 16'h86DD, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP, port_now);
        send_frame(33, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(42, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(42, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now ^ 16'h1);
        send_frame(60, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h0000, 8'd6, port_now);
        send_frame(60, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h2000, 8'd6, 16'h1234);
        send_frame(34, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h1FFF, 8'd6, port_now);
        send_frame(60, iucf_pkg::ETHERTYPE_IPV4, 8'h45, 16'h4000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(60, iucf_pkg::ETHERTYPE_IPV4, 8'hFF, 16'hFFFF, 8'h00, 16'h0000);
        send_frame(81, iucf_pkg::ETHERTYPE_IPV4, 8'h4F, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(82, iucf_pkg::ETHERTYPE_IPV4, 8'h4F, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(40, iucf_pkg::ETHERTYPE_IPV4, 8'h40, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(40, iucf_pkg::ETHERTYPE_IPV4, 8'h41, 16'h0000, iucf_pkg::PROTO_UDP,
                   port_now);
        send_frame(60, iucf_pkg::ETHERTYPE_IPV4, 8'h4F, 16'h2000, 8'd6, port_now);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (phase > 0)
            begin
                drain_verdicts();
                case (phase)
                    1: write_registers(16'hFFFF, 16'd0);
                    2: write_registers(16'($urandom), 16'd1);
                    3: write_registers(16'd17, 16'd40);
                    4: write_registers(16'd0, 16'hFFFF);
                    5: write_registers(16'($urandom), 16'($urandom_range(1, 100)));
                    6: write_registers(16'($urandom), 16'd60);
                    default: write_registers(iucf_pkg::MATCH_PORT_RESET,
                                             iucf_pkg::CAPTURE_LIMIT_RESET);
                endcase
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d frames (%0d bytes), %0d captured, across %0d settings",
                 frames_sent, bytes_sent, captures_seen, PHASE_COUNT);
        $display("of port and limit and four mixes of sender gaps and receiver stalls");
        if (fail_count == 0)
            $display("** ipv4_udp_port_capture_filter_core: PASSED **");
        else
            $display("** ipv4_udp_port_capture_filter_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
